/* hdl/gwwp_pkg.sv */
// ----------------------------------------------------------------------------
// gwwp_pkg
// Shared types, character codes and the screen code conversion for the
// greedy word wrap pager.
// ----------------------------------------------------------------------------
package gwwp_pkg;

   localparam int LEN_W = 6;
   localparam int ROW_W = 6;
   localparam int COL_W = 6;
   localparam int POS_W = 16;

   localparam logic [7:0] CHAR_SPACE = 8'd32;
   localparam logic [7:0] CHAR_TERM  = 8'd0;
   localparam logic [6:0] GLYPH_SPACE = 7'd32;

   // Configuration register indexes.
   localparam logic [1:0] CSR_FIRST_ROW   = 2'd0;
   localparam logic [1:0] CSR_ROW_COUNT   = 2'd1;
   localparam logic [1:0] CSR_DRAW_ENABLE = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic fit;
      logic emit_space;
      logic emit_glyph;
      logic emit_pend;
   } gwwp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic full_e;
      logic is_space;
      logic is_term;
      logic wlen_zero;
      logic at_limit;
      logic fit_end;
      logic fit_col_zero;
      logic draw;
      logic term;
      logic glyph_last;
      logic out_free;
   } gwwp_status_type;

   // Lower case is folded to upper case before the range mapping.
   function automatic logic [6:0] to_screen(input logic [7:0] code);
      logic [7:0] c;
      logic [6:0] res;
      c = code;
      if (c >= 8'd97 && c <= 8'd122) begin
         c = c - 8'd32;
      end
      if (c >= 8'd64 && c <= 8'd95) begin
         res = 7'(c - 8'd64);
      end else if (c >= 8'd32 && c <= 8'd63) begin
         res = c[6:0];
      end else if (c >= 8'd96 && c <= 8'd127) begin
         res = 7'(c - 8'd32);
      end else begin
         res = GLYPH_SPACE;
      end
      return res;
   endfunction

endpackage

/* hdl/gwwp_ctrl.sv */
// ----------------------------------------------------------------------------
// gwwp_ctrl
// Sequencer: accepts characters, then steps the datapath through fitting a
// finished word, emitting a separating space and its glyphs and emitting the page end.
// ----------------------------------------------------------------------------
module gwwp_ctrl
   import gwwp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  gwwp_status_type status,
   output gwwp_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_FIT   = 3'd1;
   localparam logic [2:0] ST_SPACE = 3'd2;
   localparam logic [2:0] ST_GLYPH = 3'd3;
   localparam logic [2:0] ST_PEND  = 3'd4;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid && !status.full_e) begin
               if (status.is_space) begin
                  if (!status.wlen_zero) state_in = ST_FIT;
               end else if (status.is_term) begin
                  state_in = status.wlen_zero ? ST_PEND : ST_FIT;
               end else if (status.wlen_zero && status.at_limit) begin
                  state_in = ST_PEND;
               end
            end
         end
         ST_FIT: begin
            cmd.fit = 1'b1;
            if (status.fit_end) begin
               state_in = ST_PEND;
            end else if (!status.draw) begin
               state_in = status.term ? ST_PEND : ST_IDLE;
            end else begin
               state_in = status.fit_col_zero ? ST_GLYPH : ST_SPACE;
            end
         end
         ST_SPACE: begin
            if (status.out_free) begin
               cmd.emit_space = 1'b1;
               state_in = ST_GLYPH;
            end
         end
         ST_GLYPH: begin
            if (status.out_free) begin
               cmd.emit_glyph = 1'b1;
               if (status.glyph_last) begin
                  state_in = status.term ? ST_PEND : ST_IDLE;
               end
            end
         end
         ST_PEND: begin
            if (status.out_free) begin
               cmd.emit_pend = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hdl/gwwp_datapath.sv */
// ----------------------------------------------------------------------------
// gwwp_datapath
// Layout registers, word buffer memory, configuration registers and the
// result register of the pager.
// ----------------------------------------------------------------------------
module gwwp_datapath
   import gwwp_pkg::*;
#(
   parameter int WIDTH = 40
)
(
   input  logic               clock,
   input  logic               reset,
   input  gwwp_cmd_type       cmd,
   output gwwp_status_type    status,
   input  logic [7:0]         req_char_code,
   input  logic [POS_W-1:0]   req_position,
   input  logic               req_page_begin,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [4:0]         csr_wdata,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [ROW_W-1:0]   rsp_out_row,
   output logic [COL_W-1:0]   rsp_out_col,
   output logic [6:0]         rsp_glyph_code,
   output logic               rsp_page_end,
   output logic [POS_W-1:0]   rsp_next_index,
   output logic               rsp_last
);

   localparam int AW = $clog2(WIDTH);
   localparam logic [LEN_W:0] WIDTH_X = (LEN_W + 1)'(WIDTH);
   localparam logic [LEN_W-1:0] WIDTH_L = LEN_W'(WIDTH);

   logic [4:0]       first_row_ff, row_count_ff;
   logic             draw_ff;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [LEN_W-1:0] wlen_ff, wlen_in;
   logic [POS_W-1:0] start_ff, start_in;
   logic             full_ff, full_in;
   logic             term_ff, term_in;
   logic [POS_W-1:0] next_ff, next_in;
   logic [AW-1:0]    idx_ff, idx_in;
   logic [7:0]       rd_data_ff;
   logic [7:0]       word_mem [WIDTH];

   logic             rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0] out_row_ff, out_row_in;
   logic [COL_W-1:0] out_col_ff, out_col_in;
   logic [6:0]       code_ff, code_in;
   logic             pe_ff, pe_in;
   logic [POS_W-1:0] nidx_ff, nidx_in;
   logic             last_ff, last_in;

   logic [ROW_W-1:0] row_e, limit, row_w;
   logic [COL_W-1:0] col_e, col_w, col_adv;
   logic [LEN_W-1:0] wlen_e;
   logic             full_e, is_space, is_term, at_limit, need_wrap, fit_end;
   logic             glyph_last, store_en, out_free;

   // A page_begin character restarts the layout before it is handled.
   assign row_e  = req_page_begin ? {1'b0, first_row_ff} : row_ff;
   assign col_e  = req_page_begin ? '0 : col_ff;
   assign wlen_e = req_page_begin ? '0 : wlen_ff;
   assign full_e = req_page_begin ? 1'b0 : full_ff;

   assign limit    = {1'b0, first_row_ff} + {1'b0, row_count_ff};
   assign is_space = (req_char_code == CHAR_SPACE);
   assign is_term  = (req_char_code == CHAR_TERM);
   assign at_limit = (row_e >= limit);

   assign need_wrap = (col_ff != '0) &&
                      (({1'b0, col_ff} + (LEN_W + 1)'(1) + {1'b0, wlen_ff}) > WIDTH_X);
   assign row_w   = need_wrap ? row_ff + ROW_W'(1) : row_ff;
   assign col_w   = need_wrap ? '0 : col_ff;
   assign fit_end = (row_w >= limit);
   assign col_adv = col_w + COL_W'(col_w != '0) + wlen_ff;

   assign glyph_last = (LEN_W'(idx_ff) == wlen_ff - LEN_W'(1));
   assign out_free   = !rsp_valid_ff || rsp_ready;

   assign store_en = cmd.accept && !full_e && !is_space && !is_term &&
                     !(wlen_e == '0 && at_limit) && (wlen_e < WIDTH_L);

   always_comb begin
      status.full_e       = full_e;
      status.is_space     = is_space;
      status.is_term      = is_term;
      status.wlen_zero    = (wlen_e == '0);
      status.at_limit     = at_limit;
      status.fit_end      = fit_end;
      status.fit_col_zero = (col_w == '0);
      status.draw         = draw_ff;
      status.term         = term_ff;
      status.glyph_last   = glyph_last;
      status.out_free     = out_free;
   end

   always_comb begin
      row_in   = row_ff;
      col_in   = col_ff;
      wlen_in  = wlen_ff;
      start_in = start_ff;
      full_in  = full_ff;
      term_in  = term_ff;
      next_in  = next_ff;
      idx_in   = idx_ff;

      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      out_row_in   = out_row_ff;
      out_col_in   = out_col_ff;
      code_in      = code_ff;
      pe_in        = pe_ff;
      nidx_in      = nidx_ff;
      last_in      = last_ff;

      if (cmd.accept) begin
         row_in  = row_e;
         col_in  = col_e;
         wlen_in = wlen_e;
         full_in = full_e;
         term_in = is_term;
         idx_in  = '0;
         if (!full_e) begin
            if (is_term) begin
               next_in = req_position;
            end else if (!is_space) begin
               if (wlen_e == '0 && at_limit) begin
                  next_in = req_position;
               end else begin
                  if (wlen_e == '0) start_in = req_position;
                  if (wlen_e < WIDTH_L) wlen_in = wlen_e + LEN_W'(1);
               end
            end
         end
      end

      if (cmd.fit) begin
         row_in = row_w;
         col_in = col_w;
         if (fit_end) begin
            next_in = start_ff;
         end else if (!draw_ff) begin
            // Measuring only: advance the column past the word at once.
            col_in  = col_adv;
            wlen_in = '0;
         end
      end

      if (cmd.emit_space) begin
         col_in       = col_ff + COL_W'(1);
         rsp_valid_in = 1'b1;
         out_row_in   = row_ff;
         out_col_in   = col_ff;
         code_in      = GLYPH_SPACE;
         pe_in        = 1'b0;
         nidx_in      = '0;
         last_in      = 1'b0;
      end

      if (cmd.emit_glyph) begin
         col_in       = col_ff + COL_W'(1);
         idx_in       = idx_ff + AW'(1);
         rsp_valid_in = 1'b1;
         out_row_in   = row_ff;
         out_col_in   = col_ff;
         code_in      = to_screen(rd_data_ff);
         pe_in        = 1'b0;
         nidx_in      = '0;
         last_in      = glyph_last && !term_ff;
         if (glyph_last) wlen_in = '0;
      end

      if (cmd.emit_pend) begin
         full_in      = 1'b1;
         wlen_in      = '0;
         rsp_valid_in = 1'b1;
         out_row_in   = '0;
         out_col_in   = '0;
         code_in      = '0;
         pe_in        = 1'b1;
         nidx_in      = next_ff;
         last_in      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_row_ff <= 5'd14;
         row_count_ff <= 5'd7;
         draw_ff      <= 1'b1;
         row_ff       <= '0;
         col_ff       <= '0;
         wlen_ff      <= '0;
         start_ff     <= '0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_FIRST_ROW:   first_row_ff <= csr_wdata;
               CSR_ROW_COUNT:   row_count_ff <= csr_wdata;
               CSR_DRAW_ENABLE: draw_ff      <= csr_wdata[0];
               default: begin
               end
            endcase
         end
         row_ff       <= row_in;
         col_ff       <= col_in;
         wlen_ff      <= wlen_in;
         start_ff     <= start_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      term_ff    <= term_in;
      next_ff    <= next_in;
      idx_ff     <= idx_in;
      out_row_ff <= out_row_in;
      out_col_ff <= out_col_in;
      code_ff    <= code_in;
      pe_ff      <= pe_in;
      nidx_ff    <= nidx_in;
      last_ff    <= last_in;
   end

   // Word buffer. The read address follows the next glyph index so that the
   // registered read data always belongs to the current index.
   always_ff @(posedge clock) begin
      if (store_en) begin
         word_mem[wlen_e[AW-1:0]] <= req_char_code;
      end
      rd_data_ff <= word_mem[idx_in];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_row     = out_row_ff;
   assign rsp_out_col     = out_col_ff;
   assign rsp_glyph_code  = code_ff;
   assign rsp_page_end    = pe_ff;
   assign rsp_next_index  = nidx_ff;
   assign rsp_last        = last_ff;

endmodule

/* hdl/greedy_word_wrap_pager.sv */
// ----------------------------------------------------------------------------
// greedy_word_wrap_pager
// Greedy word wrap of a character stream into screen rows, with page ends.
// ----------------------------------------------------------------------------
// A character that extends a word, or a space that follows no word, is
// accepted and produces no transaction on the result side. A space or
// terminator that ends a word is accepted, then the word is fitted (wrap
// and row limit check), then the results follow one after another: an optional
// separating space plus one glyph per stored character, read one per cycle
// from the word buffer memory while the result register can take them, and
// a page end result where the page ends. With draw_enable low the word is
// measured in the fit step alone. Results wait while the result register is
// full and not taken. The next character is accepted as soon as the last
// result of the previous one has been loaded into the result register.
module greedy_word_wrap_pager
   import gwwp_pkg::*;
#(
   parameter int WIDTH = 40
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_char_code,
   input  logic [POS_W-1:0]   req_position,
   input  logic               req_page_begin,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [ROW_W-1:0]   rsp_out_row,
   output logic [COL_W-1:0]   rsp_out_col,
   output logic [6:0]         rsp_glyph_code,
   output logic               rsp_page_end,
   output logic [POS_W-1:0]   rsp_next_index,
   output logic               rsp_last,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [4:0]         csr_wdata
);

   gwwp_cmd_type    cmd;
   gwwp_status_type status;

   gwwp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   gwwp_datapath #(
      .WIDTH (WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_char_code    (req_char_code),
      .req_position     (req_position),
      .req_page_begin   (req_page_begin),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_row      (rsp_out_row),
      .rsp_out_col      (rsp_out_col),
      .rsp_glyph_code   (rsp_glyph_code),
      .rsp_page_end     (rsp_page_end),
      .rsp_next_index   (rsp_next_index),
      .rsp_last         (rsp_last)
   );

endmodule
